// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

    // deque depth and widths; CNT_W derived from DEPTH
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;
    localparam int ADDR_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_REAR  = 2'd1,
        OP_DEL_FRONT = 2'd2,
        OP_DEL_REAR  = 2'd3
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_DENIED = 2'd3
    } status_t;

    // register index (taken from paddr[2])
    localparam logic REG_MODE = 1'b0;

    // restriction modes
    localparam logic MODE_IN_RESTRICT  = 1'b0;
    localparam logic MODE_OUT_RESTRICT = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_rear;
    } cell_ctl_t;

endpackage

// ===== rtl/cdq_cell.sv =====
module cdq_cell
    import cdq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  word_t     left_data,
    input  word_t     right_data,
    input  word_t     ins_value,
    input  logic      ins_sel,
    input  logic      rd_sel,
    input  word_t     rear_in,
    output word_t     word,
    output word_t     rear_out
);

    word_t word_reg;
    word_t word_next;

    // shift toward the rear, shift toward the front, or load at the rear slot
    always_comb
    begin
        word_next = word_reg;
        if (ctl.push_front)
        begin
            word_next = left_data;
        end
        else if (ctl.pop_front)
        begin
            word_next = right_data;
        end
        else if (ctl.push_rear && ins_sel)
        begin
            word_next = ins_value;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // rear word collection passed along the row
    assign rear_out = rd_sel ? word_reg : rear_in;
    assign word     = word_reg;

endmodule

// ===== rtl/circular_restricted_deque_core.sv =====
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+-------------------------
// command   | start, busy, op, value                          | start & !busy
// result    | done, status, removed_value, occupancy          | done, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | psel & penable & pwrite
//
// one command beat per cycle; busy is never raised
// the result beat shows in the cycle after the command beat, from the result register
// words sit in a row of cells, front word in cell 0; front ops shift the whole row
// reset clears count, mode and the result strobe; cell words are undefined until written
// the receiver cannot stall, so results are never held back
module circular_restricted_deque_core
    import cdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  word_t             value,
    output logic              done,
    output logic [1:0]        status,
    output word_t             removed_value,
    output logic [OCC_W-1:0]  occupancy
);

    logic             mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    status_t          status_reg;
    status_t          status_next;
    word_t            removed_reg;
    word_t            removed_next;
    logic [OCC_W-1:0] occ_reg;

    cell_ctl_t  ctl;
    word_t      word_w [DEPTH];
    word_t      rear_w [DEPTH];
    logic [DEPTH-1:0] ins_sel;
    logic [DEPTH-1:0] rd_sel;

    logic  accept;
    logic  denied;
    logic  is_full;
    logic  is_empty;
    op_t   op_c;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IN_RESTRICT;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    // command decode
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign op_c     = op_t'(op);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign denied   = ((mode_reg == MODE_IN_RESTRICT) && (op_c == OP_INS_FRONT)) ||
                      ((mode_reg == MODE_OUT_RESTRICT) && (op_c == OP_DEL_REAR));

    always_comb
    begin
        ctl          = '0;
        status_next  = ST_OK;
        removed_next = '0;
        count_next   = count_reg;
        if (denied)
        begin
            status_next = ST_DENIED;
        end
        else
        begin
            case (op_c)
                OP_INS_FRONT, OP_INS_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.push_front = accept && (op_c == OP_INS_FRONT);
                        ctl.push_rear  = accept && (op_c == OP_INS_REAR);
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_DEL_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_front = accept;
                        removed_next  = word_w[0];
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        removed_next = rear_w[DEPTH-1];
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // row of cells, front word in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t left_d;
        word_t right_d;
        word_t rear_i;

        assign ins_sel[i] = (count_reg == CNT_W'(i));
        assign rd_sel[i]  = (count_reg == CNT_W'(i + 1));

        if (i == 0)
        begin : g_first
            assign left_d = value;
            assign rear_i = '0;
        end
        else
        begin : g_mid
            assign left_d = word_w[i-1];
            assign rear_i = rear_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = word_w[i+1];
        end

        cdq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .ins_value  (value),
            .ins_sel    (ins_sel[i]),
            .rd_sel     (rd_sel[i]),
            .rear_in    (rear_i),
            .word       (word_w[i]),
            .rear_out   (rear_w[i])
        );
    end

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign occupancy     = occ_reg;

    // checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command beat without result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result beat without command beat");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (removed_value == '0))
        else $error("failed operation returned a word");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (occupancy == OCC_W'(DEPTH)))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_next == ST_OK)) |=> (count_reg != $past(count_reg)))
        else $error("successful operation left count unchanged");

endmodule
